// ----- hdl/itoa_pkg.sv -----
// Shared types and constants for the signed integer to decimal ASCII core.
// Depends on nothing; imported by every module of the core.
package itoa_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned NUM_DIGITS  = 10;
  localparam int unsigned BCD_W       = 4 * NUM_DIGITS;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // Classified item passed from front to back
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } itoa_entry_t;

endpackage

// ----- hdl/signed_int_to_decimal_ascii_core.sv -----
// Signed 32-bit integer to decimal ASCII text, one character per output transaction.
// Each item runs the 32-step double dabble loop, then one output register write per
// character (1..11 characters); the queue accepts new items while one converts.
// Reset: rst_n synchronous, active low; clears the queue, the sequencer and out_tvalid.
module signed_int_to_decimal_ascii_core
  import itoa_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] value (signed)
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,  // [7:0] character
  output logic              out_tlast   // final character of the number
);

  // Front: sign/magnitude split, never stalls unless the queue is full.
  // Queue: decouples input acceptance from the long conversion.
  // Back: serial binary-to-BCD, then leading-zero-suppressed emission.

  logic        push_valid, push_ready;
  itoa_entry_t push_data;
  logic        pop_valid, pop_ready;
  itoa_entry_t pop_data;

  itoa_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  itoa_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // out register inside the back end lets a new character load as the old one is taken
  itoa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- hdl/itoa_front.sv -----
// Front end: accepts the input transaction and splits it into sign and magnitude.
// Depends on itoa_pkg.
module itoa_front
  import itoa_pkg::*;
(
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,
  output logic               push_valid,
  input  logic               push_ready,
  output itoa_entry_t        push_data
);

  logic neg;

  assign neg        = in_tdata[VALUE_W-1];
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_data.neg = neg;
    // unsigned negate: most negative value maps to itself, which is the right magnitude
    push_data.mag = neg ? (VALUE_W'(0) - in_tdata) : in_tdata;
  end

endmodule

// ----- hdl/itoa_queue.sv -----
// Small register queue between front and back end.
// Depends on itoa_pkg.
module itoa_queue
  import itoa_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  itoa_entry_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output itoa_entry_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  itoa_entry_t       slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign push_ready = (fill_r != FILL_W'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/itoa_back.sv -----
// Back end: bit-serial double dabble; an output register takes one character per free cycle.
// Depends on itoa_pkg.
module itoa_back
  import itoa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  itoa_entry_t       pop_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,
  output logic              out_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_EMIT = 4'b1000
  } itoa_state_t;

  itoa_state_t       state_r, state_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt, top_idx;
  logic              sign_r, sign_nxt;
  logic              oval_r, oval_nxt;
  logic [CHAR_W-1:0] ochar_r, ochar_nxt;
  logic              olast_r, olast_nxt;
  logic              out_free;
  logic [3:0]        cur_digit;

  assign out_free   = !oval_r || out_tready;
  assign out_tvalid = oval_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;
  assign pop_ready  = (state_r == ST_IDLE);
  assign cur_digit  = bcd_r[{idx_r, 2'b00} +: 4];

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
  end

  // highest nonzero digit, zero when the value is zero
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    sign_nxt  = sign_r;
    oval_nxt  = out_free ? 1'b0 : oval_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          mag_nxt   = pop_data.mag;
          sign_nxt  = pop_data.neg;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_W-1]};
        mag_nxt = {mag_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        idx_nxt   = top_idx;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          oval_nxt = 1'b1;
          if (sign_r) begin
            ochar_nxt = ASCII_MINUS;
            olast_nxt = 1'b0;
            sign_nxt  = 1'b0;
          end else begin
            ochar_nxt = ASCII_ZERO | {4'd0, cur_digit};
            olast_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    bcd_r   <= bcd_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    sign_r  <= sign_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

endmodule
